@@ rtl/core/palette_nearest_colour_match_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the nearest palette colour match block
// Concurrent checks on a rising clock edge, switched off under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef PALETTE_NEAREST_COLOUR_MATCH_ASSERT_SVH
`define PALETTE_NEAREST_COLOUR_MATCH_ASSERT_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle
`define PNCM_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pncm check failed");

// Antecedent implies consequent in the next cycle
`define PNCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pncm check failed");

`else

`define PNCM_ASSERT_SAME(label, clk, rst, ante, cons)
`define PNCM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/pncm_pkg.sv @@
// ----------------------------------------------------------------------------
// pncm_pkg
// Shared types, constants and helpers for the nearest palette colour match.
// ----------------------------------------------------------------------------
package pncm_pkg;

  // Field widths fixed by the interface
  localparam int COMP_W = 8;
  localparam int IDX_W  = 8;
  // |dr| + |dg| + |db| peaks at 765, which fits in 10 bits
  localparam int DIST_W = 10;

  localparam int PALETTE_ENTRIES_DEF = 256;

  localparam logic [DIST_W-1:0] DIST_PEAK = DIST_W'(765);
  // Starting best distance: above any real distance, so entry 0 always wins
  localparam logic [DIST_W-1:0] DIST_INIT = '1;

  // Action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_MATCH = 1'b1;

  // Query word travelling along the chain of cells
  typedef struct packed {
    logic              valid;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;
  } pncm_token_t;

  // Palette write broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  index;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } pncm_wr_t;

  function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                 input logic [COMP_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

@@ rtl/core/pncm_cell.sv @@
// ----------------------------------------------------------------------------
// pncm_cell
// One palette entry plus a distance unit. Compares the passing query word
// against its entry and hands the word, with the best so far, to the next cell.
// ----------------------------------------------------------------------------
`include "palette_nearest_colour_match_assert.svh"

module pncm_cell
  import pncm_pkg::*;
#(
  parameter int CELL_INDEX = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  pncm_wr_t    wr,
  input  pncm_token_t tok_in,
  output pncm_token_t tok_out
);

  logic [COMP_W-1:0] entry_red;
  logic [COMP_W-1:0] entry_green;
  logic [COMP_W-1:0] entry_blue;
  logic [DIST_W-1:0] gap_sum;
  logic              closer;

  // Palette entry, written when the load address hits this cell
  always_ff @(posedge clk) begin
    if (wr.en && (wr.index == IDX_W'(CELL_INDEX))) begin
      entry_red   <= wr.red;
      entry_green <= wr.green;
      entry_blue  <= wr.blue;
    end
  end

  // Manhattan distance to the query colour
  always_comb begin
    gap_sum = DIST_W'(abs_diff(entry_red, tok_in.red))
            + DIST_W'(abs_diff(entry_green, tok_in.green))
            + DIST_W'(abs_diff(entry_blue, tok_in.blue));
    // strict compare keeps the lower index on a tie
    closer = gap_sum < tok_in.best_dist;
  end

  // Word register: valid bit under reset, payload free running
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.red   <= tok_in.red;
    tok_out.green <= tok_in.green;
    tok_out.blue  <= tok_in.blue;
    if (closer) begin
      tok_out.best_dist <= gap_sum;
      tok_out.best_idx  <= IDX_W'(CELL_INDEX);
    end else begin
      tok_out.best_dist <= tok_in.best_dist;
      tok_out.best_idx  <= tok_in.best_idx;
    end
  end

  // A word leaving a cell has seen at least this entry
  `PNCM_ASSERT_SAME(a_dist_bounded, clk, rst, tok_out.valid, tok_out.best_dist <= DIST_PEAK)
  `PNCM_ASSERT_SAME(a_idx_bounded, clk, rst, tok_out.valid, tok_out.best_idx <= IDX_W'(CELL_INDEX))

endmodule

@@ rtl/core/palette_nearest_colour_match.sv @@
// ----------------------------------------------------------------------------
// palette_nearest_colour_match
// Palette of RGB entries held in a chain of cells; a match word walks the
// chain and comes out with the index of the nearest entry (Manhattan distance).
//
//   channel  signals                        word
//   in       in_valid / in_ready            action, entry_index, red, green, blue
//   out      out_valid / out_ready          best_index
//
// A load writes its entry when it is taken and gives no result.
// A match walks the chain one cell a cycle (one register per cell), so the next
// word is taken only after its result has entered the output register.
// in_ready is low while a match is in the chain or its result sits in the skid.
// A stalled result is held in the output register, a second one in the skid.
// Reset clears the chain valid bits and handshake state; palette contents
// are undefined until loaded.
// ----------------------------------------------------------------------------
`include "palette_nearest_colour_match_assert.svh"

module palette_nearest_colour_match
  import pncm_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [COMP_W-1:0] red,
  input  logic [COMP_W-1:0] green,
  input  logic [COMP_W-1:0] blue,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  best_index
);

  pncm_token_t             tok [PALETTE_ENTRIES+1];
  pncm_token_t             tail;
  pncm_wr_t                wr;
  logic                    in_fire;
  logic                    out_free;
  logic                    busy;
  logic                    skid_valid;
  logic [IDX_W-1:0]        skid_idx;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign tail     = tok[PALETTE_ENTRIES];

  // Palette write, broadcast along the chain
  always_comb begin
    wr.en    = in_fire && (action == ACT_LOAD);
    wr.index = entry_index;
    wr.red   = red;
    wr.green = green;
    wr.blue  = blue;
  end

  // Query word entering the head cell
  always_comb begin
    tok[0].valid     = in_fire && (action == ACT_MATCH);
    tok[0].red       = red;
    tok[0].green     = green;
    tok[0].blue      = blue;
    tok[0].best_dist = DIST_INIT;
    tok[0].best_idx  = '0;
  end

  // Chain of cells, one per palette entry
  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
    pncm_cell #(
      .CELL_INDEX(k)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .wr     (wr),
      .tok_in (tok[k]),
      .tok_out(tok[k+1])
    );
  end

  // Busy flag, skid and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      skid_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_fire && (action == ACT_MATCH)) begin
        busy <= 1'b1;
      end
      if (tail.valid) begin
        if (out_free) begin
          out_valid <= 1'b1;
          busy      <= 1'b0;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (skid_valid && out_free) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
        busy       <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (tail.valid) begin
      if (out_free) begin
        best_index <= tail.best_idx;
      end else begin
        skid_idx <= tail.best_idx;
      end
    end else if (skid_valid && out_free) begin
      best_index <= skid_idx;
    end
  end

  // Checks
  `PNCM_ASSERT_SAME(a_tail_busy, clk, rst, tail.valid, busy)
  `PNCM_ASSERT_SAME(a_tail_no_skid, clk, rst, tail.valid, !skid_valid)
  `PNCM_ASSERT_SAME(a_skid_out_held, clk, rst, skid_valid, out_valid && busy)
  `PNCM_ASSERT_NEXT(a_match_busy, clk, rst, in_fire && (action == ACT_MATCH), busy)

endmodule
